// File: rtl/core/ipv6p_pkg.sv
// Shared types, codes and helpers for the IPv6 address text parser.
`timescale 1ns / 1ps

package ipv6p_pkg;

    localparam int unsigned CH_W       = 8;
    localparam int unsigned GROUP_W    = 16;
    localparam int unsigned MAX_GROUPS = 8;
    localparam int unsigned COUNT_W    = 4;
    localparam int unsigned DIGIT_W    = 3;
    localparam int unsigned HALF_W     = 64;

    localparam logic [CH_W-1:0]    COLON_CH   = 8'h3A;
    localparam logic [CH_W-1:0]    TERM_CH    = 8'h00;
    localparam logic [3:0]         NIBBLE     = 4'hF;
    localparam logic [COUNT_W-1:0] GROUPS_MAX = 4'd8;
    localparam logic [DIGIT_W-1:0] DIGITS_MAX = 3'd4;

    typedef enum logic [2:0] {
        PH_START       = 3'd0,
        PH_LEAD_COLON  = 3'd1,
        PH_AFTER_COLON = 3'd2,
        PH_AFTER_DC    = 3'd3,
        PH_IN_GROUP    = 3'd4,
        PH_ERROR       = 3'd5
    } phase_t;

    typedef logic [MAX_GROUPS-1:0][GROUP_W-1:0] group_array_t;

    typedef struct packed {
        phase_t               phase;
        logic [GROUP_W-1:0]   group_value;
        logic [DIGIT_W-1:0]   digit_count;
        logic [COUNT_W-1:0]   left_count;
        logic [COUNT_W-1:0]   right_count;
        logic                 double_colon_seen;
    } parse_ctrl_t;

    typedef struct packed {
        logic              valid_res;
        logic [HALF_W-1:0] address_high;
        logic [HALF_W-1:0] address_low;
    } parse_result_t;

    localparam parse_ctrl_t CTRL_CLEAR = '{
        phase:             PH_START,
        group_value:       '0,
        digit_count:       '0,
        left_count:        '0,
        right_count:       '0,
        double_colon_seen: 1'b0
    };

    // bit 4 set when the byte is a hex digit, low nibble is its value
    function automatic logic [4:0] hex_decode(input logic [CH_W-1:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            r = {1'b1, (c[3:0] + 4'd9) & NIBBLE};
        end
        return r;
    endfunction

endpackage

// File: rtl/core/ipv6p_step.sv
// Per-character parse step and final address expansion.
`timescale 1ns / 1ps

module ipv6p_step
    import ipv6p_pkg::*;
(
    input  logic [CH_W-1:0] ch,
    input  parse_ctrl_t     ctrl,
    input  group_array_t    left_groups,
    input  group_array_t    right_groups,
    output parse_ctrl_t     ctrl_next,
    output group_array_t    left_next,
    output group_array_t    right_next,
    output logic            is_term,
    output parse_result_t   result
);

    logic [4:0]         hex;
    logic               is_hex;
    logic               is_colon;
    logic               full;
    logic               ok;
    logic               do_store;
    logic [COUNT_W-1:0] lc_s;
    logic [COUNT_W-1:0] rc_s;
    logic [COUNT_W:0]   total;
    logic [GROUP_W-1:0] g;
    logic [MAX_GROUPS*GROUP_W-1:0] addr;

    assign hex      = hex_decode(ch);
    assign is_hex   = hex[4];
    assign is_colon = (ch == COLON_CH);
    assign is_term  = (ch == TERM_CH);
    assign full     = (COUNT_W'(ctrl.left_count + ctrl.right_count) >= GROUPS_MAX);

    always_comb
    begin
        ctrl_next  = ctrl;
        left_next  = left_groups;
        right_next = right_groups;
        do_store   = 1'b0;
        ok         = 1'b0;
        lc_s       = ctrl.left_count;
        rc_s       = ctrl.right_count;
        total      = '0;
        g          = '0;
        addr       = '0;
        result     = '0;

        if (is_term) begin
            unique case (ctrl.phase)
                PH_START, PH_AFTER_DC:
                    ok = 1'b1;
                PH_IN_GROUP:
                begin
                    ok       = 1'b1;
                    do_store = 1'b1;
                end
                default:
                    ok = 1'b0;
            endcase
        end else begin
            unique case (ctrl.phase)
                PH_START:
                begin
                    if (is_colon) begin
                        ctrl_next.phase = PH_LEAD_COLON;
                    end else if (is_hex && !full) begin
                        ctrl_next.group_value = GROUP_W'(hex[3:0]);
                        ctrl_next.digit_count = DIGIT_W'(1);
                        ctrl_next.phase       = PH_IN_GROUP;
                    end else begin
                        ctrl_next.phase = PH_ERROR;
                    end
                end
                PH_LEAD_COLON:
                begin
                    if (is_colon) begin
                        ctrl_next.double_colon_seen = 1'b1;
                        ctrl_next.phase             = PH_AFTER_DC;
                    end else begin
                        ctrl_next.phase = PH_ERROR;
                    end
                end
                PH_AFTER_COLON:
                begin
                    if (is_colon && !ctrl.double_colon_seen) begin
                        ctrl_next.double_colon_seen = 1'b1;
                        ctrl_next.phase             = PH_AFTER_DC;
                    end else if (is_hex && !full) begin
                        ctrl_next.group_value = GROUP_W'(hex[3:0]);
                        ctrl_next.digit_count = DIGIT_W'(1);
                        ctrl_next.phase       = PH_IN_GROUP;
                    end else begin
                        ctrl_next.phase = PH_ERROR;
                    end
                end
                PH_AFTER_DC:
                begin
                    if (is_hex && !full) begin
                        ctrl_next.group_value = GROUP_W'(hex[3:0]);
                        ctrl_next.digit_count = DIGIT_W'(1);
                        ctrl_next.phase       = PH_IN_GROUP;
                    end else begin
                        ctrl_next.phase = PH_ERROR;
                    end
                end
                PH_IN_GROUP:
                begin
                    if (is_hex) begin
                        if (ctrl.digit_count >= DIGITS_MAX) begin
                            ctrl_next.phase = PH_ERROR;
                        end else begin
                            ctrl_next.group_value = {ctrl.group_value[GROUP_W-5:0], hex[3:0]};
                            ctrl_next.digit_count = ctrl.digit_count + DIGIT_W'(1);
                        end
                    end else if (is_colon) begin
                        do_store        = 1'b1;
                        ctrl_next.phase = PH_AFTER_COLON;
                    end else begin
                        ctrl_next.phase = PH_ERROR;
                    end
                end
                default:
                    ctrl_next.phase = PH_ERROR;
            endcase
        end

        // left side written by index, right side is a shift line (newest at tap 0)
        if (do_store) begin
            if (ctrl.double_colon_seen) begin
                right_next = {right_groups[MAX_GROUPS-2:0], ctrl.group_value};
                rc_s       = ctrl.right_count + COUNT_W'(1);
            end else begin
                left_next[ctrl.left_count[2:0]] = ctrl.group_value;
                lc_s = ctrl.left_count + COUNT_W'(1);
            end
            ctrl_next.left_count  = lc_s;
            ctrl_next.right_count = rc_s;
            ctrl_next.group_value = '0;
            ctrl_next.digit_count = '0;
        end

        if (is_term) begin
            total = (COUNT_W+1)'(lc_s) + (COUNT_W+1)'(rc_s);
            if (ctrl.double_colon_seen) begin
                ok = ok && (total <= (COUNT_W+1)'(GROUPS_MAX));
            end else begin
                ok = ok && (total == (COUNT_W+1)'(GROUPS_MAX));
            end
            for (int i = 0; i < MAX_GROUPS; i++) begin
                if (COUNT_W'(i) < lc_s) begin
                    g = left_next[i];
                end else if ((COUNT_W+1)'(i) + (COUNT_W+1)'(rc_s)
                             >= (COUNT_W+1)'(GROUPS_MAX)) begin
                    g = right_next[MAX_GROUPS-1-i];
                end else begin
                    g = '0;
                end
                addr[(MAX_GROUPS-1-i)*GROUP_W +: GROUP_W] = g;
            end
            result.valid_res    = ok;
            result.address_high = ok ? addr[2*HALF_W-1:HALF_W] : '0;
            result.address_low  = ok ? addr[HALF_W-1:0] : '0;
            ctrl_next           = CTRL_CLEAR;
        end
    end

endmodule

// File: rtl/core/ipv6p_out_reg.sv
// Result register on the output stream side.
`timescale 1ns / 1ps

module ipv6p_out_reg
    import ipv6p_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  parse_result_t res_in,
    input  logic          tready,
    output logic          tvalid,
    output logic          free,
    output parse_result_t res_out
);

    logic          valid_reg;
    logic          valid_next;
    parse_result_t res_reg;

    assign free       = !valid_reg || tready;
    assign valid_next = load || (valid_reg && !tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            res_reg <= res_in;
        end
    end

    assign tvalid  = valid_reg;
    assign res_out = res_reg;

endmodule

// File: rtl/core/ipv6_address_text_parser.sv
// Top level of the IPv6 address text parser: input register, parser state, result register.
// Throughput: one character word per cycle, sustained; a result stalls input only while full.
// Result path: the terminating zero byte waits in the input register until the result register
//   has room; the parse step then loads the result word into the result register.
// Reset: rst_n clears the parser control state and both valid flags; the group stores
//   are left as they are and are only read after being written.
`timescale 1ns / 1ps

module ipv6_address_text_parser
    import ipv6p_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [7:0]    s_axis_tdata,   // [7:0] ch
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [127:0]  m_axis_tdata,   // [63:0] address_high, [127:64] address_low
    output logic          m_axis_tuser    // [0] valid_res
);

    logic            in_valid_reg;
    logic            in_valid_next;
    logic [CH_W-1:0] ch_reg;
    parse_ctrl_t     ctrl_reg;
    parse_ctrl_t     ctrl_next;
    group_array_t    left_reg;
    group_array_t    left_next;
    group_array_t    right_reg;
    group_array_t    right_next;
    parse_result_t   result;
    parse_result_t   res_out;
    logic            is_term;
    logic            out_free;
    logic            advance;
    logic            in_take;

    ipv6p_step u_step (
        .ch           (ch_reg),
        .ctrl         (ctrl_reg),
        .left_groups  (left_reg),
        .right_groups (right_reg),
        .ctrl_next    (ctrl_next),
        .left_next    (left_next),
        .right_next   (right_next),
        .is_term      (is_term),
        .result       (result)
    );

    // a terminator only moves on when the result register has room
    assign advance       = in_valid_reg && (!is_term || out_free);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign in_valid_next = in_take || (in_valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
            ctrl_reg     <= CTRL_CLEAR;
        end else begin
            in_valid_reg <= in_valid_next;
            if (advance) begin
                ctrl_reg <= ctrl_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take) begin
            ch_reg <= s_axis_tdata;
        end
        if (advance) begin
            left_reg  <= left_next;
            right_reg <= right_next;
        end
    end

    ipv6p_out_reg u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (advance && is_term),
        .res_in  (result),
        .tready  (m_axis_tready),
        .tvalid  (m_axis_tvalid),
        .free    (out_free),
        .res_out (res_out)
    );

    assign m_axis_tdata = {res_out.address_low, res_out.address_high};
    assign m_axis_tuser = res_out.valid_res;

    // invalid text must carry a zero address
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("invalid result with nonzero address");

    a_group_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (5'(ctrl_reg.left_count) + 5'(ctrl_reg.right_count)) <= 5'(GROUPS_MAX))
        else $error("more than eight groups held");

    a_right_needs_dc: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_reg.right_count != '0 |-> ctrl_reg.double_colon_seen)
        else $error("right groups without double colon");

    a_clear_after_term: assert property (@(posedge clk) disable iff (!rst_n)
        advance && is_term |=> ctrl_reg == CTRL_CLEAR)
        else $error("parser state not cleared after terminator");

endmodule

// File: sim/ipv6_address_text_parser_checker.sv
// Checker for the IPv6 address text parser: predicts each address from the input words.
`timescale 1ns / 1ps

module ipv6_address_text_parser_checker
    import ipv6p_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    input  logic          s_axis_tready,
    input  logic [7:0]    s_axis_tdata,   // [7:0] ch
    input  logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    input  logic [127:0]  m_axis_tdata,   // [63:0] address_high, [127:64] address_low
    input  logic          m_axis_tuser,   // [0] valid_res
    output int            mismatches,
    output int            addresses_due,
    output int            addresses_seen,
    output int            addresses_valid
);

    localparam int MAX_REPORTS = 40;

    // parser state as the block should hold it
    phase_t               ph;
    logic [GROUP_W-1:0]   grp_acc;
    logic [DIGIT_W-1:0]   n_digits;
    logic [GROUP_W-1:0]   lhs [MAX_GROUPS];
    logic [GROUP_W-1:0]   rhs [MAX_GROUPS];
    logic [COUNT_W-1:0]   n_left;
    logic [COUNT_W-1:0]   n_right;
    logic                 dc_seen;

    parse_result_t        address_q [$];

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_REPORTS)
        begin
            $display("[%0t] MISMATCH: %s", $time, msg);
        end
        mismatches++;
    endtask

    function automatic logic hex_nibble(input logic [7:0] c, output logic [3:0] v);
        logic [7:0] d;
        d = 8'h00;
        if (c >= "0" && c <= "9")
        begin
            d = c - "0";
        end
        else if (c >= "A" && c <= "F")
        begin
            d = c - "A" + 8'd10;
        end
        else if (c >= "a" && c <= "f")
        begin
            d = c - "a" + 8'd10;
        end
        v = d[3:0];
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
    endfunction

    task automatic clear_parse();
        ph       = PH_START;
        grp_acc  = '0;
        n_digits = '0;
        n_left   = '0;
        n_right  = '0;
        dc_seen  = 1'b0;
    endtask

    // a group may only start while fewer than eight are held on both sides together
    task automatic open_group(input logic [3:0] v);
        if (int'(n_left) + int'(n_right) >= int'(GROUPS_MAX))
        begin
            ph = PH_ERROR;
        end
        else
        begin
            grp_acc  = {12'h000, v};
            n_digits = 3'd1;
            ph       = PH_IN_GROUP;
        end
    endtask

    task automatic close_group();
        if (dc_seen)
        begin
            rhs[n_right[2:0]] = grp_acc;
            n_right = n_right + COUNT_W'(1);
        end
        else
        begin
            lhs[n_left[2:0]] = grp_acc;
            n_left = n_left + COUNT_W'(1);
        end
        grp_acc  = '0;
        n_digits = '0;
    endtask

    task automatic push_address(input logic ok);
        parse_result_t r;
        int            total;
        int            rstart;
        logic [15:0]   g;
        r      = '0;
        total  = int'(n_left) + int'(n_right);
        rstart = int'(MAX_GROUPS) - int'(n_right);
        if (ok)
        begin
            ok = dc_seen ? (total <= int'(MAX_GROUPS)) : (total == int'(MAX_GROUPS));
        end
        if (ok)
        begin
            // '::' fills the gap between the left and right groups with zeros
            for (int i = 0; i < int'(MAX_GROUPS); i++)
            begin
                g = 16'h0000;
                if (i < int'(n_left))
                begin
                    g = lhs[i];
                end
                else if (i >= rstart)
                begin
                    g = rhs[i - rstart];
                end
                if (i < 4)
                begin
                    r.address_high = {r.address_high[47:0], g};
                end
                else
                begin
                    r.address_low = {r.address_low[47:0], g};
                end
            end
        end
        r.valid_res = ok;
        address_q.push_back(r);
    endtask

    task automatic parse_char(input logic [7:0] c);
        logic [3:0] v;
        logic       hex;
        logic       ok;
        hex = hex_nibble(c, v);
        if (c == TERM_CH)
        begin
            ok = 1'b0;
            case (ph)
                PH_START, PH_AFTER_DC: ok = 1'b1;
                PH_IN_GROUP:
                begin
                    close_group();
                    ok = 1'b1;
                end
                default: ok = 1'b0;
            endcase
            push_address(ok);
            clear_parse();
        end
        else
        begin
            case (ph)
                PH_START:
                begin
                    if (c == COLON_CH)
                        ph = PH_LEAD_COLON;
                    else if (hex)
                        open_group(v);
                    else
                        ph = PH_ERROR;
                end
                PH_LEAD_COLON:
                begin
                    if (c == COLON_CH)
                    begin
                        dc_seen = 1'b1;
                        ph      = PH_AFTER_DC;
                    end
                    else
                    begin
                        ph = PH_ERROR;
                    end
                end
                PH_AFTER_COLON:
                begin
                    if (c == COLON_CH && !dc_seen)
                    begin
                        dc_seen = 1'b1;
                        ph      = PH_AFTER_DC;
                    end
                    else if (hex)
                    begin
                        open_group(v);
                    end
                    else
                    begin
                        ph = PH_ERROR;
                    end
                end
                PH_AFTER_DC:
                begin
                    if (hex)
                        open_group(v);
                    else
                        ph = PH_ERROR;
                end
                PH_IN_GROUP:
                begin
                    if (hex)
                    begin
                        if (n_digits >= DIGITS_MAX)
                        begin
                            ph = PH_ERROR;
                        end
                        else
                        begin
                            grp_acc  = {grp_acc[11:0], v};
                            n_digits = n_digits + DIGIT_W'(1);
                        end
                    end
                    else if (c == COLON_CH)
                    begin
                        close_group();
                        ph = PH_AFTER_COLON;
                    end
                    else
                    begin
                        ph = PH_ERROR;
                    end
                end
                default: ph = PH_ERROR;
            endcase
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        parse_result_t want;
        if (!rst_n)
        begin
            clear_parse();
            address_q.delete();
            mismatches      = 0;
            addresses_seen  = 0;
            addresses_valid = 0;
            addresses_due  <= 0;
        end
        else
        begin
            // output side first: a word leaving now always belongs to an older text
            if (m_axis_tvalid && m_axis_tready)
            begin
                addresses_seen++;
                if (address_q.size() == 0)
                begin
                    report_mismatch("address word with none pending");
                end
                else
                begin
                    want = address_q.pop_front();
                    if (want.valid_res)
                        addresses_valid++;
                    if (m_axis_tuser !== want.valid_res)
                        report_mismatch($sformatf("valid_res %b, want %b",
                                                  m_axis_tuser, want.valid_res));
                    if (m_axis_tdata[63:0] !== want.address_high)
                        report_mismatch($sformatf("address_high %h, want %h",
                                                  m_axis_tdata[63:0], want.address_high));
                    if (m_axis_tdata[127:64] !== want.address_low)
                        report_mismatch($sformatf("address_low %h, want %h",
                                                  m_axis_tdata[127:64], want.address_low));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                parse_char(s_axis_tdata);
            end
            addresses_due <= address_q.size();
        end
    end

endmodule

// File: sim/ipv6_address_text_parser_tb.sv
// Testbench top for the IPv6 address text parser: stimulus, handshake timing and verdict.
`timescale 1ns / 1ps

module ipv6_address_text_parser_tb;

    import ipv6p_pkg::*;

    localparam int TEXT_WORDS     = 1650;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AT_WORD   = 20;
    localparam int DRAIN_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT = 4000;

    logic          clk = 1'b0;
    logic          rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [7:0]    s_axis_tdata;
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [127:0]  m_axis_tdata;
    logic          m_axis_tuser;

    int            mismatches;
    int            addresses_due;
    int            addresses_seen;
    int            addresses_valid;

    logic [7:0]    text_bytes [$];
    int            words_sent  = 0;
    int            idle_cycles = 0;
    bit            calm        = 1'b0;
    bit            rx_hold     = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    ipv6_address_text_parser i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    ipv6_address_text_parser_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .mismatches      (mismatches),
        .addresses_due   (addresses_due),
        .addresses_seen  (addresses_seen),
        .addresses_valid (addresses_valid)
    );

    function automatic int draw_gap();
        return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10)
            return 8'h30 + 8'(v);
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(v - 4'd10);
    endfunction

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            text_bytes.push_back(s[i]);
        end
    endtask

    task automatic add_group(input int nd);
        int style;
        style = $urandom_range(0, 7);
        for (int i = 0; i < nd; i++)
        begin
            if (style == 0)
                text_bytes.push_back(hex_char(4'hF));
            else if (style == 1)
                text_bytes.push_back(hex_char(4'h0));
            else
                text_bytes.push_back(hex_char(4'($urandom_range(0, 15))));
        end
    endtask

    // groups left of '::', the '::' itself, groups right of it; long_idx gets five digits
    task automatic build_text(input bit use_dc, input int nl, input int nr,
                              input int long_idx, input bit second_dc);
        for (int i = 0; i < nl; i++)
        begin
            if (i > 0)
                push_str(":");
            add_group(i == long_idx ? 5 : $urandom_range(1, 4));
        end
        if (use_dc)
            push_str("::");
        for (int i = 0; i < nr; i++)
        begin
            if (i > 0)
                push_str(":");
            add_group(nl + i == long_idx ? 5 : $urandom_range(1, 4));
        end
        if (second_dc)
        begin
            push_str("::");
            add_group($urandom_range(1, 4));
        end
    endtask

    task automatic send_word(input logic [7:0] b);
        int gap;
        gap = (calm || rx_hold) ? 0 : draw_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        words_sent++;
    endtask

    task automatic send_text();
        foreach (text_bytes[i])
        begin
            send_word(text_bytes[i]);
        end
        send_word(TERM_CH);
        text_bytes.delete();
    endtask

    initial
    begin
        int kind;
        int nl;
        int nr;
        int pos;
        bit use_dc;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty text, lone leading colon, bare '::', second '::', long group,
        // trailing single colon, stray byte
        send_text();
        push_str(":a");
        send_text();
        push_str("::");
        send_text();
        push_str("1::2::");
        send_text();
        push_str("12345");
        send_text();
        push_str("a:");
        send_text();
        push_str("g");
        send_text();

        while (words_sent < TEXT_WORDS)
        begin
            calm = ($urandom_range(0, 5) == 0);
            kind = $urandom_range(0, 99);
            use_dc = ($urandom_range(0, 2) != 0);
            nl = use_dc ? $urandom_range(0, 8) : 8;
            nr = use_dc ? $urandom_range(0, 8 - nl) : 0;
            if (kind < 60)
            begin
                build_text(use_dc, nl, nr, -1, 1'b0);
            end
            else if (kind < 88)
            begin
                case ($urandom_range(0, 6))
                    0:
                    begin
                        // one group too many, with or without '::'
                        if (use_dc)
                            build_text(1'b1, nl, 9 - nl, -1, 1'b0);
                        else
                            build_text(1'b0, 9, 0, -1, 1'b0);
                    end
                    1: build_text(1'b0, $urandom_range(1, 7), 0, -1, 1'b0);
                    2: build_text(1'b0, 8, 0, $urandom_range(0, 7), 1'b0);
                    3: build_text(1'b1, $urandom_range(0, 3), $urandom_range(0, 3), -1, 1'b1);
                    4:
                    begin
                        build_text(use_dc, nl, nr, -1, 1'b0);
                        push_str(":");
                    end
                    5:
                    begin
                        build_text(use_dc, nl, nr, -1, 1'b0);
                        pos = $urandom_range(0, text_bytes.size() - 1);
                        text_bytes[pos] = 8'($urandom_range(1, 255));
                    end
                    default:
                    begin
                        build_text(use_dc, nl, nr, -1, 1'b0);
                        pos = $urandom_range(0, text_bytes.size() - 1);
                        if ($urandom_range(0, 1))
                            text_bytes.insert(pos, 8'($urandom_range(1, 255)));
                        else
                            text_bytes.delete(pos);
                    end
                endcase
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                begin
                    case ($urandom_range(0, 3))
                        0: text_bytes.push_back(COLON_CH);
                        1: text_bytes.push_back(hex_char(4'($urandom_range(0, 15))));
                        default: text_bytes.push_back(8'($urandom_range(1, 255)));
                    endcase
                end
            end
            send_text();
        end
        calm = 1'b0;
        s_axis_tvalid <= 1'b0;

        do
            @(posedge clk);
        while (addresses_due != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d text words; checked %0d addresses, %0d of them well-formed.",
                 words_sent, addresses_seen, addresses_valid);
        $display("Output was held off once for %0d cycles to back up the input.",
                 HOLD_CYCLES);
        if (mismatches == 0 && addresses_due == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // result side: random hold-off per word, plus one long stall to fill the block
    initial
    begin
        int  gap;
        int  taken;
        bit  held;
        taken = 0;
        held  = 1'b0;
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (taken == HOLD_AT_WORD && !held)
            begin
                gap     = HOLD_CYCLES;
                held    = 1'b1;
                rx_hold = 1'b1;
            end
            else
            begin
                gap = calm ? 0 : draw_gap();
            end
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rx_hold = 1'b0;
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_axis_tvalid && m_axis_tready));
            taken++;
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule

// File: files.f
rtl/core/ipv6p_pkg.sv
rtl/core/ipv6p_step.sv
rtl/core/ipv6p_out_reg.sv
rtl/core/ipv6_address_text_parser.sv
sim/ipv6_address_text_parser_checker.sv
sim/ipv6_address_text_parser_tb.sv
